### hdl/bspa_pkg.sv
// Shared constants, status codes and controller/datapath link types for the
// bitmap slot pool allocator. No dependencies.
package bspa_pkg;

  localparam int SLOTS   = 1024;
  localparam int MAX_RUN = 64;
  localparam int WORD_W  = 64;
  localparam int WORDS   = SLOTS / WORD_W;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int WA_W    = $clog2(WORDS);
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int EXT_W   = 2 * WORD_W;
  localparam int LEN_W   = 7;
  localparam int POOL_W  = 11;
  localparam int STAT_W  = 2;

  localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(1024);

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic latch;
    logic rd_first;
    logic scan;
    logic mark_hi;
    logic mark_lo;
    logic clr_first;
    logic clr_second;
    logic set_nofit;
    logic set_range;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic req_ok;
    logic hit;
    logic last_word;
    logic spans;
  } stat_t;

endpackage

### hdl/bspa_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on bspa_pkg for field widths.
interface bspa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [bspa_pkg::IDX_W-1:0]  start_index;
  logic [bspa_pkg::LEN_W-1:0]  run_length;

  modport source (output valid, op, start_index, run_length, input ready);
  modport sink   (input valid, op, start_index, run_length, output ready);
endinterface

interface bspa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bspa_pkg::STAT_W-1:0] status;
  logic [bspa_pkg::IDX_W-1:0]  slot_index;
  logic [bspa_pkg::CNT_W-1:0]  free_count;

  modport source (output valid, status, slot_index, free_count, input ready);
  modport sink   (input valid, status, slot_index, free_count, output ready);
endinterface

### hdl/bspa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bspa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bspa_datapath.sv
// Datapath: pool registers, used bitmap RAM with row valid bits, word-wide
// first-fit search and run set/clear logic. Depends on bspa_pkg, bspa_ram.
module bspa_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bspa_pkg::POOL_W-1:0] cfg_data,
  input  logic                        req_op,
  input  logic [bspa_pkg::IDX_W-1:0]  req_start,
  input  logic [bspa_pkg::LEN_W-1:0]  req_len,
  input  bspa_pkg::cmd_t              cmd,
  output bspa_pkg::stat_t             stat,
  output logic [bspa_pkg::STAT_W-1:0] rsp_status,
  output logic [bspa_pkg::IDX_W-1:0]  rsp_slot,
  output logic [bspa_pkg::CNT_W-1:0]  rsp_free
);

  localparam int WORD_W = bspa_pkg::WORD_W;
  localparam int BIT_W  = bspa_pkg::BIT_W;
  localparam int WA_W   = bspa_pkg::WA_W;
  localparam int IDX_W  = bspa_pkg::IDX_W;
  localparam int CNT_W  = bspa_pkg::CNT_W;
  localparam int LEN_W  = bspa_pkg::LEN_W;
  localparam int EXT_W  = bspa_pkg::EXT_W;
  localparam int HI_W   = CNT_W - BIT_W;

  function automatic logic [CNT_W-1:0] eff_of(input logic [bspa_pkg::POOL_W-1:0] ps);
    if (int'(ps) > bspa_pkg::SLOTS) begin
      return CNT_W'(bspa_pkg::SLOTS);
    end
    return CNT_W'(ps);
  endfunction

  // Bit p set where a free run of len ends at p; runs of 2^k built by doubling.
  function automatic logic [EXT_W-1:0] run_ends(input logic [EXT_W-1:0] v,
                                                input logic [LEN_W-1:0] len);
    logic [EXT_W-1:0] g;
    logic [EXT_W-1:0] acc;
    g   = v;
    acc = '1;
    for (int k = 0; k < LEN_W; k++) begin
      if (len[k]) begin
        acc = g & (acc << (1 << k));
      end
      g = g & (g << (1 << k));
    end
    return acc;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  // Count of free bits at the top of a word that is not all free.
  function automatic logic [LEN_W-1:0] top_free(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] h;
    logic [BIT_W-1:0] t;
    h = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!v[i]) begin
        h = BIT_W'(i);
      end
    end
    t = ~h;
    return LEN_W'(t);
  endfunction

  function automatic logic [WORD_W-1:0] range_mask(input logic [BIT_W-1:0] lo,
                                                   input logic [BIT_W-1:0] hi);
    return ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (~hi));
  endfunction

  function automatic logic [LEN_W-1:0] popcount(input logic [WORD_W-1:0] v);
    logic [LEN_W-1:0] s;
    s = '0;
    for (int i = 0; i < WORD_W; i++) begin
      s = s + LEN_W'(v[i]);
    end
    return s;
  endfunction

  logic [bspa_pkg::POOL_W-1:0] pool_size;
  logic [CNT_W-1:0]            free_slots;
  logic [CNT_W-1:0]            eff;
  logic [CNT_W-1:0]            last_m1;
  logic [HI_W-1:0]             size_hi;
  logic                        op_q;
  logic [IDX_W-1:0]            start_q;
  logic [LEN_W-1:0]            len_q;
  logic [WA_W-1:0]             w;
  logic [WA_W-1:0]             hit_w;
  logic [WA_W-1:0]             start_w;
  logic [WA_W-1:0]             raddr;
  logic [WA_W-1:0]             waddr;
  logic [LEN_W-1:0]            carry;
  logic [LEN_W-1:0]            carry_next;
  logic [WORD_W-1:0]           rdata_ram;
  logic [WORD_W-1:0]           rdata;
  logic [WORD_W-1:0]           prev;
  logic [WORD_W-1:0]           cur;
  logic [WORD_W-1:0]           inpool;
  logic [WORD_W-1:0]           freew;
  logic [WORD_W-1:0]           hits;
  logic [WORD_W-1:0]           clr_mask;
  logic [WORD_W-1:0]           wdata;
  logic [EXT_W-1:0]            ends;
  logic [BIT_W-1:0]            hit_p;
  logic [BIT_W-1:0]            p;
  logic [IDX_W-1:0]            first_q;
  logic [IDX_W-1:0]            first;
  logic                        spans_q;
  logic                        spans;
  logic                        hit;
  logic                        free_spans;
  logic                        rd_valid;
  logic                        we;
  logic [bspa_pkg::WORDS-1:0]  row_valid;
  logic [BIT_W:0]              fend;
  logic [CNT_W:0]              free_end;
  logic [LEN_W-1:0]            clr_cnt;
  logic                        len_ok;
  logic [bspa_pkg::STAT_W-1:0] res_status;
  logic [IDX_W-1:0]            res_slot;

  assign eff     = eff_of(pool_size);
  assign last_m1 = eff - CNT_W'(1);
  assign size_hi = eff[CNT_W-1:BIT_W];
  assign start_w = start_q[IDX_W-1:BIT_W];
  assign rdata   = rd_valid ? rdata_ram : '0;

  // in-pool mask of the word under scan
  always_comb begin
    if (size_hi > HI_W'(w)) begin
      inpool = '1;
    end else if (size_hi == HI_W'(w)) begin
      inpool = ~({WORD_W{1'b1}} << eff[BIT_W-1:0]);
    end else begin
      inpool = '0;
    end
  end

  assign freew      = ~rdata & inpool;
  assign ends       = run_ends({freew, ~({WORD_W{1'b1}} >> carry)}, len_q);
  assign hits       = ends[EXT_W-1:WORD_W];
  assign hit        = |hits;
  assign p          = lowest_one(hits);
  assign first      = {w, p} - IDX_W'(len_q) + IDX_W'(1);
  assign spans      = first[IDX_W-1:BIT_W] != w;
  assign carry_next = (&freew) ? LEN_W'(WORD_W) : top_free(freew);

  assign len_ok     = (len_q != '0) && (len_q <= LEN_W'(bspa_pkg::MAX_RUN));
  assign free_end   = (CNT_W+1)'(start_q) + (CNT_W+1)'(len_q);
  assign fend       = (BIT_W+1)'(start_q[BIT_W-1:0]) + (BIT_W+1)'(len_q) - (BIT_W+1)'(1);
  assign free_spans = fend[BIT_W];

  assign stat.is_free   = op_q;
  assign stat.req_ok    = (op_q == bspa_pkg::OP_FREE) ?
                          (len_ok && (free_end <= (CNT_W+1)'(eff))) :
                          (len_ok && (free_slots != '0));
  assign stat.hit       = hit;
  assign stat.last_word = last_m1[IDX_W-1:BIT_W] == w;
  assign stat.spans     = (op_q == bspa_pkg::OP_FREE) ? free_spans : spans_q;

  always_comb begin
    raddr = w;
    if (cmd.rd_first) begin
      raddr = (op_q == bspa_pkg::OP_FREE) ? start_w : '0;
    end else if (cmd.scan) begin
      raddr = w + WA_W'(1);
    end else if (cmd.clr_first) begin
      raddr = start_w + WA_W'(1);
    end
  end

  always_comb begin
    we       = 1'b0;
    waddr    = hit_w;
    wdata    = cur;
    clr_mask = '0;
    if (cmd.mark_hi) begin
      we    = 1'b1;
      wdata = cur | range_mask(spans_q ? '0 : first_q[BIT_W-1:0], hit_p);
    end else if (cmd.mark_lo) begin
      we    = 1'b1;
      waddr = hit_w - WA_W'(1);
      wdata = prev | range_mask(first_q[BIT_W-1:0], '1);
    end else if (cmd.clr_first) begin
      we       = 1'b1;
      waddr    = start_w;
      clr_mask = range_mask(start_q[BIT_W-1:0], free_spans ? '1 : fend[BIT_W-1:0]);
      wdata    = rdata & ~clr_mask;
    end else if (cmd.clr_second) begin
      we       = 1'b1;
      waddr    = start_w + WA_W'(1);
      clr_mask = range_mask('0, fend[BIT_W-1:0]);
      wdata    = rdata & ~clr_mask;
    end
  end

  // only slots that go from used to free are counted
  assign clr_cnt = popcount(rdata & clr_mask);

  bspa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (bspa_pkg::WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_ram)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size  <= bspa_pkg::POOL_RESET;
      free_slots <= eff_of(bspa_pkg::POOL_RESET);
      row_valid  <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= row_valid[raddr];
      if (cfg_we) begin
        pool_size  <= cfg_data;
        free_slots <= eff_of(cfg_data);
        row_valid  <= '0;
      end
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      if (cmd.mark_hi) begin
        free_slots <= free_slots - CNT_W'(len_q);
      end
      if (cmd.clr_first || cmd.clr_second) begin
        free_slots <= free_slots + CNT_W'(clr_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q       <= req_op;
      start_q    <= req_start;
      len_q      <= req_len;
      res_status <= bspa_pkg::ST_OK;
      res_slot   <= '0;
    end
    if (cmd.rd_first) begin
      w     <= '0;
      carry <= '0;
    end
    if (cmd.scan) begin
      w     <= w + WA_W'(1);
      carry <= carry_next;
      if (hit) begin
        hit_w   <= w;
        hit_p   <= p;
        cur     <= rdata;
        first_q <= first;
        spans_q <= spans;
      end else begin
        prev <= rdata;
      end
    end
    if (cmd.mark_hi) begin
      res_slot <= first_q;
    end
    if (cmd.set_nofit) begin
      res_status <= bspa_pkg::ST_NOFIT;
    end
    if (cmd.set_range) begin
      res_status <= bspa_pkg::ST_RANGE;
    end
    if (cmd.load_out) begin
      rsp_status <= res_status;
      rsp_slot   <= res_slot;
      rsp_free   <= free_slots;
    end
  end

endmodule

### hdl/bspa_ctrl.sv
// Controller state machine: sequences precheck, word scan, run marking and
// clearing, and owns the response valid flag. Depends on bspa_pkg.
module bspa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            rsp_ready,
  input  bspa_pkg::stat_t stat,
  output logic            req_ready,
  output logic            rsp_valid,
  output bspa_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_ASCAN  = 3'd2;
  localparam logic [2:0] S_AMARK  = 3'd3;
  localparam logic [2:0] S_AMARK2 = 3'd4;
  localparam logic [2:0] S_FCLR1  = 3'd5;
  localparam logic [2:0] S_FCLR2  = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (!stat.req_ok) begin
          cmd.set_range = stat.is_free;
          cmd.set_nofit = !stat.is_free;
          state_next    = S_FIN;
        end else begin
          cmd.rd_first = 1'b1;
          state_next   = stat.is_free ? S_FCLR1 : S_ASCAN;
        end
      end
      S_ASCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_next = S_AMARK;
        end else if (stat.last_word) begin
          cmd.set_nofit = 1'b1;
          state_next    = S_FIN;
        end
      end
      S_AMARK: begin
        cmd.mark_hi = 1'b1;
        state_next  = stat.spans ? S_AMARK2 : S_FIN;
      end
      S_AMARK2: begin
        cmd.mark_lo = 1'b1;
        state_next  = S_FIN;
      end
      S_FCLR1: begin
        cmd.clr_first = 1'b1;
        state_next    = stat.spans ? S_FCLR2 : S_FIN;
      end
      S_FCLR2: begin
        cmd.clr_second = 1'b1;
        state_next     = S_FIN;
      end
      S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/bitmap_slot_pool_allocator.sv
// Top level of the bitmap slot pool allocator: controller plus datapath.
// Depends on bspa_pkg, bspa_if, bspa_ram, bspa_datapath, bspa_ctrl.
//
//   channel | dir | handshake    | word
//   --------+-----+--------------+-------------------------------------
//   req     | in  | valid/ready  | op, start_index, run_length
//   rsp     | out | valid/ready  | status, slot_index, free_count
//   cfg     | in  | cfg_we only  | cfg_data = pool_size
//
// One request at a time. Allocate: accept, precheck, then a scan of the
// 64-slot bitmap words through the single RAM read port up to the word
// where the run ends (1..16), then marking of the one or two words that the
// run covers and a result step. Free: one RMW per word (one or two words).
// A failed precheck goes straight to the result step.
// Reset and pool_size writes clear the map through per-word valid bits at
// once; there is no clearing pass. A pending response sits in an output
// register, so the next request is accepted while it waits.
module bitmap_slot_pool_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bspa_pkg::POOL_W-1:0] cfg_data,
  bspa_req_if.sink                    req,
  bspa_rsp_if.source                  rsp
);

  bspa_pkg::cmd_t  cmd;
  bspa_pkg::stat_t stat;
  logic            req_ready;
  logic            rsp_valid;

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

  // sequencing only; all slot state lives in the datapath
  bspa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .cmd       (cmd)
  );

  // bitmap RAM, free count, first-fit search, output word register
  bspa_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .req_op     (req.op),
    .req_start  (req.start_index),
    .req_len    (req.run_length),
    .cmd        (cmd),
    .stat       (stat),
    .rsp_status (rsp.status),
    .rsp_slot   (rsp.slot_index),
    .rsp_free   (rsp.free_count)
  );

  // one request in flight: no back-to-back accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  // double frees must never push the count above SLOTS, the largest pool
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (int'(rsp.free_count) <= bspa_pkg::SLOTS))
    else $error("free count above pool size");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != bspa_pkg::ST_OK)) |-> (rsp.slot_index == '0))
    else $error("slot index set on failed request");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status == bspa_pkg::ST_OK || rsp.status == bspa_pkg::ST_NOFIT ||
                   rsp.status == bspa_pkg::ST_RANGE))
    else $error("undefined status code");

endmodule
